// ===== rtl/dmbr_pkg.sv =====
package dmbr_pkg;

    localparam int STORE_DEPTH_DEFAULT = 4096;

    localparam int DATA_W   = 8;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 12;
    localparam int FREE_W   = 13;
    localparam int CAP_W    = 13;

    localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;
    localparam int               CAP_MIN   = 2;

    localparam logic [DATA_W-1:0] DELIM_BYTE = 8'h0A;
    localparam logic [DATA_W-1:0] NUL_BYTE   = 8'h00;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 40;
    localparam int M_PAD_W   = M_TDATA_W - DATA_W - COUNT_W - FREE_W;

    // APB register map
    localparam int   APB_ADDR_W   = 3;
    localparam int   APB_DATA_W   = 32;
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH  = 2'd0,
        KIND_POP   = 2'd1,
        KIND_PEEK  = 2'd2,
        KIND_RESET = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_EMPTY  = 2'd1,
        STAT_NOROOM = 2'd2,
        STAT_BAD    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EXEC  = 3'b010,
        ST_DELIM = 3'b100
    } state_t;

endpackage

// ===== rtl/dmbr_ram.sv =====
module dmbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/delimited_message_byte_ring.sv =====
// A result is presented on m_axis once its item has been accepted (with its store read) and
// then executed in ST_EXEC, which waits while the result register is still full. A new item
// is taken only in ST_IDLE; a push that commits a message also passes through ST_DELIM,
// writing the delimiter through the single store write port. One item is in flight at a time.
// Reset (rst_n low, asynchronous): queue empty, capacity 4096, no result pending;
// store contents are undefined and never used before being written.
module delimited_message_byte_ring
    import dmbr_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [KIND_W-1:0]     s_axis_tuser,   // [1:0] kind
    input  logic                  s_axis_tlast,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [7:0] out_byte, [19:8] message_count,
                                                  // [32:20] free_bytes, rest zero
    output logic [STATUS_W-1:0]   m_axis_tuser,   // [1:0] status
    output logic                  m_axis_tlast,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int PW = AW + 1;
    localparam int CW = (PW > CAP_W) ? PW : CAP_W;

    function automatic logic [AW-1:0] next_addr(input logic [AW-1:0] p,
                                                input logic [PW-1:0] cap);
        logic [PW-1:0] inc;
        inc = {1'b0, p} + PW'(1);
        return (inc >= cap) ? '0 : AW'(inc);
    endfunction

    function automatic logic [PW-1:0] free_of(input logic [PW-1:0] used,
                                              input logic [PW-1:0] cap);
        return (used >= cap) ? '0 : cap - used;
    endfunction

    // configuration
    logic [CAP_W-1:0] capacity_reg;
    logic [CW-1:0]    cap_ext;
    logic [PW-1:0]    eff_cap;
    logic             cfg_we;

    // queue state
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] peek_reg, peek_next;
    logic [PW-1:0] plen_reg, plen_next;
    logic          povf_reg, povf_next;
    logic          pbad_reg, pbad_next;
    logic [PW-1:0] used_reg, used_next;
    logic [AW-1:0] held_reg, held_next;
    logic [PW-1:0] poplen_reg, poplen_next;

    // item in flight
    state_t              state_reg, state_next;
    kind_t               kind_reg;
    logic [DATA_W-1:0]   byte_reg;
    logic                last_reg;
    logic [AW-1:0]       rd_addr_reg;
    logic [AW-1:0]       delim_addr_reg, delim_addr_next;

    // result register
    logic                m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]   ob_reg, ob_next;
    logic                eom_reg, eom_next;
    status_t             status_reg, status_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [FREE_W-1:0]   free_reg;

    // store port
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;
    logic [AW-1:0]     rd_addr;

    logic              s_accept;
    logic              out_free;
    logic              finish;
    logic [AW+1:0]     pop_sum;
    logic [AW+1:0]     pop_wrap;
    logic [PW-1:0]     free_now;
    logic              fits;
    logic [PW-1:0]     plen1;
    logic              ovf1;
    logic [AW-1:0]     wp1;
    logic              bad1;

    // effective capacity, clamped between CAP_MIN and the store size
    always_comb
    begin
        cap_ext = CW'(capacity_reg);
        if (cap_ext < CW'(CAP_MIN))
        begin
            eff_cap = PW'(CAP_MIN);
        end
        else if (cap_ext > CW'(STORE_DEPTH))
        begin
            eff_cap = PW'(STORE_DEPTH);
        end
        else
        begin
            eff_cap = PW'(cap_ext);
        end
    end

    assign cfg_we = psel && penable && pwrite && pready
                    && (paddr[APB_ADDR_W-1] == REG_CAPACITY);
    assign pready = 1'b1;
    assign prdata = (paddr[APB_ADDR_W-1] == REG_CAPACITY) ? APB_DATA_W'(capacity_reg) : '0;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign finish        = (state_reg == ST_EXEC) && out_free;

    // read address for the incoming item: the peek pointer for a peek, else head plus popped bytes, wrapped
    always_comb
    begin
        pop_sum  = (AW+2)'(head_reg) + (AW+2)'(poplen_reg);
        pop_wrap = pop_sum;
        if (pop_wrap >= (AW+2)'(eff_cap))
        begin
            pop_wrap = pop_wrap - (AW+2)'(eff_cap);
        end
        if (pop_wrap >= (AW+2)'(eff_cap))
        begin
            pop_wrap = '0;
        end
        rd_addr = (kind_t'(s_axis_tuser) == KIND_PEEK) ? peek_reg : AW'(pop_wrap);
    end

    dmbr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s_accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // push arithmetic
    always_comb
    begin
        free_now = free_of(used_reg, eff_cap);
        fits     = !povf_reg && ((PW+1)'(plen_reg) + (PW+1)'(2) <= (PW+1)'(free_now));
        plen1    = fits ? plen_reg + PW'(1) : plen_reg;
        ovf1     = povf_reg || !fits;
        wp1      = fits ? next_addr(wp_reg, eff_cap) : wp_reg;
        bad1     = pbad_reg || (byte_reg == NUL_BYTE) || (byte_reg == DELIM_BYTE);
    end

    // execute
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        wp_next         = wp_reg;
        peek_next       = peek_reg;
        plen_next       = plen_reg;
        povf_next       = povf_reg;
        pbad_next       = pbad_reg;
        used_next       = used_reg;
        held_next       = held_reg;
        poplen_next     = poplen_reg;
        delim_addr_next = delim_addr_reg;
        ob_next         = '0;
        eom_next        = 1'b0;
        status_next     = STAT_OK;
        ram_we          = 1'b0;
        ram_waddr       = wp_reg;
        ram_wdata       = byte_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                    case (kind_reg)
                        KIND_PUSH:
                        begin
                            ram_we = fits;
                            if (last_reg)
                            begin
                                wp_next = tail_reg;
                                if (bad1)
                                begin
                                    status_next = STAT_BAD;
                                end
                                else if (ovf1 || ((PW+1)'(plen1) + (PW+1)'(1)
                                                  > (PW+1)'(free_now)))
                                begin
                                    status_next = STAT_NOROOM;
                                end
                                else
                                begin
                                    // commit; delimiter goes out next cycle
                                    delim_addr_next = wp1;
                                    tail_next       = next_addr(wp1, eff_cap);
                                    wp_next         = next_addr(wp1, eff_cap);
                                    used_next       = used_reg + plen1 + PW'(1);
                                    held_next       = held_reg + AW'(1);
                                    state_next      = ST_DELIM;
                                end
                                plen_next = '0;
                                povf_next = 1'b0;
                                pbad_next = 1'b0;
                            end
                            else
                            begin
                                wp_next   = wp1;
                                plen_next = plen1;
                                povf_next = ovf1;
                                pbad_next = bad1;
                            end
                        end
                        KIND_POP:
                        begin
                            if (held_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else if (ram_rdata == DELIM_BYTE)
                            begin
                                eom_next    = 1'b1;
                                head_next   = next_addr(rd_addr_reg, eff_cap);
                                peek_next   = next_addr(rd_addr_reg, eff_cap);
                                used_next   = (used_reg >= poplen_reg + PW'(1))
                                              ? used_reg - poplen_reg - PW'(1) : '0;
                                held_next   = held_reg - AW'(1);
                                poplen_next = '0;
                            end
                            else
                            begin
                                ob_next     = ram_rdata;
                                poplen_next = poplen_reg + PW'(1);
                            end
                        end
                        KIND_PEEK:
                        begin
                            if (held_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else if (ram_rdata == DELIM_BYTE)
                            begin
                                eom_next  = 1'b1;
                                peek_next = head_reg;
                            end
                            else
                            begin
                                ob_next   = ram_rdata;
                                peek_next = next_addr(peek_reg, eff_cap);
                            end
                        end
                        KIND_RESET:
                        begin
                            head_next   = '0;
                            tail_next   = '0;
                            wp_next     = '0;
                            peek_next   = '0;
                            plen_next   = '0;
                            povf_next   = 1'b0;
                            pbad_next   = 1'b0;
                            used_next   = '0;
                            held_next   = '0;
                            poplen_next = '0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DELIM:
            begin
                ram_we     = 1'b1;
                ram_waddr  = delim_addr_reg;
                ram_wdata  = DELIM_BYTE;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (finish)
        begin
            m_valid_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            head_reg     <= '0;
            tail_reg     <= '0;
            wp_reg       <= '0;
            peek_reg     <= '0;
            plen_reg     <= '0;
            povf_reg     <= 1'b0;
            pbad_reg     <= 1'b0;
            used_reg     <= '0;
            held_reg     <= '0;
            poplen_reg   <= '0;
        end
        else if (cfg_we)
        begin
            // new wrap point; empty the queue
            capacity_reg <= pwdata[CAP_W-1:0];
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            head_reg     <= '0;
            tail_reg     <= '0;
            wp_reg       <= '0;
            peek_reg     <= '0;
            plen_reg     <= '0;
            povf_reg     <= 1'b0;
            pbad_reg     <= 1'b0;
            used_reg     <= '0;
            held_reg     <= '0;
            poplen_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            wp_reg       <= wp_next;
            peek_reg     <= peek_next;
            plen_reg     <= plen_next;
            povf_reg     <= povf_next;
            pbad_reg     <= pbad_next;
            used_reg     <= used_next;
            held_reg     <= held_next;
            poplen_reg   <= poplen_next;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            kind_reg    <= kind_t'(s_axis_tuser);
            byte_reg    <= s_axis_tdata[DATA_W-1:0];
            last_reg    <= s_axis_tlast;
            rd_addr_reg <= rd_addr;
        end
        delim_addr_reg <= delim_addr_next;
        if (finish)
        begin
            ob_reg     <= ob_next;
            eom_reg    <= eom_next;
            status_reg <= status_next;
            count_reg  <= COUNT_W'(held_next);
            free_reg   <= FREE_W'(free_of(used_next, eff_cap));
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{M_PAD_W{1'b0}}, free_reg, count_reg, ob_reg};
    assign m_axis_tuser  = status_reg;
    assign m_axis_tlast  = eom_reg;

    // committed bytes exist only while messages are held
    a_used_needs_msgs: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg == '0 |-> used_reg == '0)
        else $error("used bytes without held messages");

    a_used_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= eff_cap)
        else $error("used bytes exceed capacity");

    a_store_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg != ST_IDLE)
        else $error("store written with no transaction in flight");

    a_exec_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXEC && !out_free |=> state_reg == ST_EXEC)
        else $error("transaction left execute while result slot was full");

endmodule
